/* rtl/sample_without_replacement_macros.svh */
`ifndef SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define SWR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/swr_pkg.sv */
package swr_pkg;

   localparam int BASE_W      = 24;
   localparam int POOL_CNT_W  = 11;
   localparam int SAMPLE_W    = 16;
   localparam int RAND_W      = 10;
   localparam int ID_W        = 25;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_INDEX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd2;

   localparam logic [BASE_W-1:0]     BASE_RESET   = 24'd0;
   localparam logic [POOL_CNT_W-1:0] POOL_RESET   = 11'd1;
   localparam logic [SAMPLE_W-1:0]   SAMPLE_RESET = 16'd1;
   localparam logic [SAMPLE_W-1:0]   SAMPLE_MIN   = 16'd2;

   typedef struct packed {
      logic accept;
      logic commit;
      logic sweep;
   } swr_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic sweep_done;
      logic rsp_free;
      logic run_end;
   } swr_status_type;

endpackage

/* rtl/sample_without_replacement.sv */
// After the request beat is taken the controller moves to EXEC, and once the
// result register is free the draw is committed into it and rsp_tvalid rises.
// Both pool reads happen as the request is taken and the write-back at the commit; no new request is taken before that.
// Refill: after reset, after a write to any of the three registers and after the
// last draw of a run without replacement, the pool RAM is rewritten with identity,
// one entry per cycle over the effective pool count (up to POOL_DEPTH entries);
// req_tready stays low meanwhile. Reset is synchronous: registers to 0, 1, 1.
module sample_without_replacement #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swr_pkg::REQ_DATA_W-1:0]  req_tdata,   // [9:0] random_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swr_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [24:0] sample_id
   output logic                            rsp_tlast,   // last_of_run
   output logic                            rsp_tuser,   // index_error
   input  logic                            csr_we,
   input  logic [swr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import swr_pkg::*;

   swr_cmd_type    cmd;
   swr_status_type status;
   logic [ID_W-1:0] sample_id;

   swr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   swr_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .random_index (req_tdata[RAND_W-1:0]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .sample_id    (sample_id),
      .last_of_run  (rsp_tlast),
      .index_error  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(sample_id);

`include "sample_without_replacement_macros.svh"

   `SWR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second request taken while a draw is in flight")
   `SWR_ASSERT_SAME(a_error_beat, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata == '0) && !rsp_tlast, "error beat carries data or last")
   `SWR_ASSERT_SAME(a_rsp_from_req, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without a request two cycles earlier")

endmodule

/* rtl/swr_ctrl.sv */
module swr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swr_pkg::swr_status_type status,
   output swr_pkg::swr_cmd_type    cmd
);
   import swr_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit = (state_ff == ST_EXEC) && status.rsp_free;
   assign cmd.sweep  = (state_ff == ST_SWEEP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.rsp_free) state_in = status.run_end ? ST_SWEEP : ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
      if (status.cfg_write) state_in = ST_SWEEP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/swr_datapath.sv */
module swr_datapath #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  swr_pkg::swr_cmd_type             cmd,
   output swr_pkg::swr_status_type          status,
   input  logic                            csr_we,
   input  logic [swr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [swr_pkg::RAND_W-1:0]      random_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swr_pkg::ID_W-1:0]        sample_id,
   output logic                            last_of_run,
   output logic                            index_error
);
   import swr_pkg::*;

   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POOL_CNT_W) ? CNT_W : POOL_CNT_W;
   localparam int SC_W   = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(POOL_DEPTH);

   logic [ADDR_W-1:0] pool_mem [POOL_DEPTH];

   logic [BASE_W-1:0]     base_ff, base_in;
   logic [POOL_CNT_W-1:0] pool_cnt_ff, pool_cnt_in;
   logic [SAMPLE_W-1:0]   sample_cnt_ff, sample_cnt_in;
   logic [CNT_W-1:0]      live_ff, live_in;
   logic [SAMPLE_W-1:0]   draws_ff, draws_in;
   logic [ADDR_W-1:0]     sweep_idx_ff, sweep_idx_in;
   logic [CMP_W-1:0]      pos_ff, pos_in;
   logic                  err_ff, err_in;
   logic [ADDR_W-1:0]     rd0_ff, rd1_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       sample_id_ff, sample_id_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   logic                  cfg_hit;
   logic [CMP_W-1:0]      pool_ext, eff_ext, pos_ext, live_ext;
   logic [CNT_W-1:0]      eff_cnt, live_m1;
   logic                  with_repl;
   logic [SAMPLE_W-1:0]   draws_next;
   logic                  last_draw;
   logic [ADDR_W-1:0]     entry;
   logic [ID_W-1:0]       id_sum;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa, mem_wd, rd_addr0, rd_addr1;

   assign cfg_hit = csr_we && ((csr_index == CSR_BASE_INDEX) ||
                               (csr_index == CSR_POOL_COUNT) ||
                               (csr_index == CSR_SAMPLE_COUNT));

   assign pool_ext = CMP_W'(pool_cnt_ff);

   always_comb begin
      if (pool_ext == '0) begin
         eff_ext = CMP_W'(1);
      end else if (pool_ext > DEPTH_C) begin
         eff_ext = DEPTH_C;
      end else begin
         eff_ext = pool_ext;
      end
   end

   assign eff_cnt   = eff_ext[CNT_W-1:0];
   assign with_repl = (sample_cnt_ff < SAMPLE_MIN) ||
                      (SC_W'(sample_cnt_ff) >= SC_W'(eff_cnt));

   assign pos_ext  = CMP_W'(random_index);
   assign live_ext = CMP_W'(live_ff);
   assign live_m1  = live_ff - CNT_W'(1);
   assign rd_addr0 = pos_ext[ADDR_W-1:0];
   assign rd_addr1 = live_m1[ADDR_W-1:0];

   assign draws_next = draws_ff + SAMPLE_W'(1);
   assign last_draw  = (sample_cnt_ff == '0) || (draws_next >= sample_cnt_ff);
   assign entry      = with_repl ? pos_ff[ADDR_W-1:0] : rd0_ff;
   assign id_sum     = ID_W'(base_ff) + ID_W'(entry);

   assign mem_we = cmd.sweep || (cmd.commit && !err_ff && !with_repl);
   assign mem_wa = cmd.sweep ? sweep_idx_ff : pos_ff[ADDR_W-1:0];
   assign mem_wd = cmd.sweep ? sweep_idx_ff : rd1_ff;

   assign status.cfg_write  = cfg_hit;
   assign status.sweep_done = (CNT_W'(sweep_idx_ff) == (eff_cnt - CNT_W'(1)));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.run_end    = !err_ff && last_draw && !with_repl;

   always_comb begin
      base_in       = base_ff;
      pool_cnt_in   = pool_cnt_ff;
      sample_cnt_in = sample_cnt_ff;
      live_in       = live_ff;
      draws_in      = draws_ff;
      sweep_idx_in  = sweep_idx_ff;
      pos_in        = pos_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff;
      sample_id_in  = sample_id_ff;
      last_in       = last_ff;
      error_in      = error_ff;

      if (cmd.accept) begin
         pos_in = pos_ext;
         err_in = (pos_ext >= live_ext);
      end

      if (cmd.commit) begin
         if (!err_ff) begin
            if (!with_repl) live_in = live_m1;
            draws_in = draws_next;
            if (last_draw) begin
               draws_in     = '0;
               live_in      = eff_cnt;
               sweep_idx_in = '0;
            end
         end
         rsp_valid_in = 1'b1;
         sample_id_in = err_ff ? '0 : id_sum;
         last_in      = !err_ff && last_draw;
         error_in     = err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.sweep) begin
         sweep_idx_in = sweep_idx_ff + ADDR_W'(1);
         live_in      = eff_cnt;
      end

      if (cfg_hit) begin
         case (csr_index)
            CSR_BASE_INDEX:   base_in       = csr_wdata[BASE_W-1:0];
            CSR_POOL_COUNT:   pool_cnt_in   = csr_wdata[POOL_CNT_W-1:0];
            CSR_SAMPLE_COUNT: sample_cnt_in = csr_wdata[SAMPLE_W-1:0];
            default:          base_in       = base_ff;
         endcase
         draws_in     = '0;
         sweep_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= BASE_RESET;
         pool_cnt_ff   <= POOL_RESET;
         sample_cnt_ff <= SAMPLE_RESET;
         live_ff       <= CNT_W'(1);
         draws_ff      <= '0;
         sweep_idx_ff  <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         pool_cnt_ff   <= pool_cnt_in;
         sample_cnt_ff <= sample_cnt_in;
         live_ff       <= live_in;
         draws_ff      <= draws_in;
         sweep_idx_ff  <= sweep_idx_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      sample_id_ff <= sample_id_in;
      last_ff      <= last_in;
      error_ff     <= error_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) pool_mem[mem_wa] <= mem_wd;
      if (cmd.accept) begin
         rd0_ff <= pool_mem[rd_addr0];
         rd1_ff <= pool_mem[rd_addr1];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign sample_id   = sample_id_ff;
   assign last_of_run = last_ff;
   assign index_error = error_ff;

endmodule

/* sim/sample_without_replacement_checker.sv */
module sample_without_replacement_checker #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [swr_pkg::REQ_DATA_W-1:0]  req_tdata,   // [9:0] random_index
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [swr_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [24:0] sample_id
   input  logic                            rsp_tlast,   // last_of_run
   input  logic                            rsp_tuser,   // index_error
   input  logic                            csr_we,
   input  logic [swr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              outstanding,
   output logic [swr_pkg::POOL_CNT_W-1:0]  live_hint,
   output int                              draws_seen,
   output int                              runs_seen,
   output int                              bad_index_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import swr_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] sample_id;
      logic            last_of_run;
      logic            index_error;
   } draw_result_type;

   logic [BASE_W-1:0]     base_reg;
   logic [POOL_CNT_W-1:0] pool_reg;
   logic [SAMPLE_W-1:0]   sample_reg;
   logic [RAND_W-1:0]     pool_ids [POOL_DEPTH];
   logic [POOL_CNT_W-1:0] live;
   logic [SAMPLE_W-1:0]   draws_done;
   draw_result_type       expected_draws [$];

   function automatic logic [POOL_CNT_W-1:0] pool_size();
      if (pool_reg == '0) return POOL_CNT_W'(1);
      if (pool_reg > POOL_DEPTH) return POOL_CNT_W'(POOL_DEPTH);
      return pool_reg;
   endfunction

   function automatic bit with_replacement();
      return sample_reg < SAMPLE_MIN || sample_reg >= SAMPLE_W'(pool_size());
   endfunction

   task automatic restart_run();
      for (int i = 0; i < POOL_DEPTH; i++) pool_ids[i] = RAND_W'(i);
      live = pool_size();
      draws_done = '0;
   endtask

   task automatic draw_sample(input logic [RAND_W-1:0] pos, output draw_result_type res);
      logic [RAND_W-1:0] entry;
      bit                finished;
      res = '0;
      if (live == '0 || live > POOL_DEPTH || {1'b0, pos} >= live) begin
         res.index_error = 1'b1;
      end else begin
         if (with_replacement()) begin
            entry = pos;
         end else begin
            // swap-remove: last live id fills the drawn slot
            entry = pool_ids[pos];
            live = live - 1'b1;
            pool_ids[pos] = pool_ids[live[RAND_W-1:0]];
         end
         draws_done = draws_done + 1'b1;
         finished = (sample_reg == '0) || (draws_done >= sample_reg);
         if (finished) restart_run();
         res.sample_id = ID_W'(base_reg) + ID_W'(entry);
         res.last_of_run = finished;
      end
   endtask

   always @(posedge clock) begin
      draw_result_type want;
      draw_result_type got;
      if (reset) begin
         base_reg = BASE_RESET;
         pool_reg = POOL_RESET;
         sample_reg = SAMPLE_RESET;
         restart_run();
         expected_draws.delete();
         mismatches = 0;
         draws_seen = 0;
         runs_seen = 0;
         bad_index_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_INDEX: begin
                  base_reg = csr_wdata[BASE_W-1:0];
                  restart_run();
               end
               CSR_POOL_COUNT: begin
                  pool_reg = csr_wdata[POOL_CNT_W-1:0];
                  restart_run();
               end
               CSR_SAMPLE_COUNT: begin
                  sample_reg = csr_wdata[SAMPLE_W-1:0];
                  restart_run();
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sample_id = rsp_tdata[ID_W-1:0];
            got.last_of_run = rsp_tlast;
            got.index_error = rsp_tuser;
            draws_seen++;
            if (got.last_of_run) runs_seen++;
            if (got.index_error) bad_index_seen++;
            if (expected_draws.size() == 0) begin
               $error("result beat with nothing pending: sample_id %0d", got.sample_id);
               mismatches++;
            end else begin
               want = expected_draws.pop_front();
               if (got.sample_id !== want.sample_id) begin
                  $error("sample_id: expected %0d, got %0d", want.sample_id, got.sample_id);
                  mismatches++;
               end
               if (got.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         want.last_of_run, got.last_of_run);
                  mismatches++;
               end
               if (got.index_error !== want.index_error) begin
                  $error("index_error: expected %0b, got %0b",
                         want.index_error, got.index_error);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            draw_sample(req_tdata[RAND_W-1:0], want);
            expected_draws.push_back(want);
         end
      end
      outstanding <= expected_draws.size();
      live_hint <= live;
   end

endmodule

/* sim/sample_without_replacement_test.sv */
module sample_without_replacement_test;
   timeunit 1ns;
   timeprecision 1ps;

   import swr_pkg::*;

   localparam int POOL_DEPTH    = 1024;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_DRAWS   = 102;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // [9:0] random_index
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // [24:0] sample_id
   logic                   rsp_tlast;         // last_of_run
   logic                   rsp_tuser;         // index_error
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int                     mismatches;
   int                     pending;
   logic [POOL_CNT_W-1:0]  live_hint;
   int                     draws_seen;
   int                     runs_seen;
   int                     bad_index_seen;

   logic                   calm         = 1'b0;
   logic                   hold_request = 1'b0;
   logic                   held         = 1'b0;
   int                     hold_left    = 0;
   int                     cycle_count  = 0;
   int                     settings     = 0;

   sample_without_replacement #(.POOL_DEPTH(POOL_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sample_without_replacement_checker #(.POOL_DEPTH(POOL_DEPTH)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (pending),
      .live_hint      (live_hint),
      .draws_seen     (draws_seen),
      .runs_seen      (runs_seen),
      .bad_index_seen (bad_index_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sample_without_replacement_test: FAIL");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         held <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !held) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         held <= 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 37);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned base, input int unsigned pool,
                            input int unsigned count);
      write_reg(CSR_BASE_INDEX, base);
      write_reg(CSR_POOL_COUNT, pool);
      write_reg(CSR_SAMPLE_COUNT, count);
      settings++;
   endtask

   task automatic send_draw(input logic [RAND_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(idx);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic random_draw();
      logic [RAND_W-1:0] idx;
      if ($urandom_range(99) < 85) idx = RAND_W'($urandom_range(int'(live_hint) - 1, 0));
      else idx = RAND_W'($urandom);
      send_draw(idx);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int unsigned pool_pick;
      int unsigned count_pick;
      int          mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: one id, draws with replacement
      send_draw(10'd0);
      send_draw(10'd1);
      send_draw(10'd1023);
      drain();

      // top base, oversized pool clamps, zero count marks every draw last
      configure(24'hFFFFFF, 2047, 0);
      send_draw(10'd1023);
      send_draw(10'd0);
      send_draw(10'd512);
      drain();

      // zero pool acts as one
      configure(0, 0, 16'hFFFF);
      send_draw(10'd0);
      send_draw(10'd1);
      drain();

      // small run without replacement, refill, then a write to an unused index
      configure(1000, 3, 2);
      send_draw(10'd2);
      send_draw(10'd2);
      send_draw(10'd0);
      send_draw(10'd1);
      drain();
      write_reg(CSR_UNUSED, 24'h5A5A5A);
      send_draw(10'd1);
      drain();

      // full pool, short run: full-depth refill
      configure(24'h000123, 1024, 2);
      send_draw(10'd1023);
      send_draw(10'd1023);
      send_draw(10'd0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm <= (phase == 7);
         hold_request <= (phase == 2);
         mode = (phase < 4) ? phase : $urandom_range(9);
         case (mode)
            0: begin
               pool_pick = 1024;
               count_pick = $urandom_range(1023, 200);
            end
            1: begin
               pool_pick = $urandom_range(2047, 0);
               count_pick = $urandom_range(65535, 0);
            end
            2: begin
               pool_pick = $urandom_range(64, 1);
               count_pick = $urandom_range(65535, pool_pick);
            end
            3: begin
               pool_pick = $urandom_range(1024, 1);
               count_pick = $urandom_range(1, 0);
            end
            default: begin
               pool_pick = $urandom_range(40, 3);
               count_pick = $urandom_range(pool_pick - 1, 2);
            end
         endcase
         configure($urandom & 24'hFFFFFF, pool_pick, count_pick);
         for (int n = 0; n < PHASE_DRAWS; n++) begin
            if (phase == 5 && n == PHASE_DRAWS / 2) drain();
            random_draw();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d draws over %0d register settings: %0d runs completed,",
               draws_seen, settings, runs_seen);
      $display("%0d out-of-range indices rejected", bad_index_seen);
      if (mismatches == 0) begin
         $display("sample_without_replacement_test: PASS");
      end else begin
         $display("sample_without_replacement_test: FAIL");
      end
      $finish;
   end

endmodule

/* sample_without_replacement.f */
+incdir+rtl
rtl/swr_pkg.sv
rtl/swr_ctrl.sv
rtl/swr_datapath.sv
rtl/sample_without_replacement.sv
sim/sample_without_replacement_checker.sv
sim/sample_without_replacement_test.sv
